FILE: hdl/dasc_pkg.sv
// ----------------------------------------------------------------------------
// dasc_pkg: shared types and constants for the decimal add/sub/compare block
// Holds digit widths, operation codes, sequencer states and the digit-unit
// request/response structs.
// ----------------------------------------------------------------------------
package dasc_pkg;

  localparam int DIGIT_W = 4;
  localparam int OP_W    = 2;
  localparam int FLAG_W  = 3;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [DIGIT_W:0]   DIGIT_BASE = 5'd10;

  // operation codes carried on the input tuser; any other code compares only
  localparam logic [OP_W-1:0] OP_SUM  = 2'd0;
  localparam logic [OP_W-1:0] OP_DIFF = 2'd1;
  localparam logic [OP_W-1:0] OP_CMP  = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN_RD = 6'b000010,
    ST_SCAN_OP = 6'b000100,
    ST_EMIT_RD = 6'b001000,
    ST_EMIT_OP = 6'b010000,
    ST_FINAL   = 6'b100000
  } seq_state_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] x;
    logic [DIGIT_W-1:0] y;
    logic               cin;
    logic               sub;
  } alu_req_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               cout;
    logic               x_lt_y;
    logic               x_eq_y;
  } alu_res_t;

  function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    return r;
  endfunction

endpackage

FILE: hdl/decimal_add_sub_compare.sv
// ----------------------------------------------------------------------------
// decimal_add_sub_compare: multi-digit BCD add, absolute difference, compare
// Loads digit pairs, then scans and emits result digits through one shared
// digit unit under a small sequencer.
// ----------------------------------------------------------------------------
// Digit pairs load one beat per cycle while idle, least significant first;
// digits above nine load as nine and pairs past DIGITS are dropped with
// overflow set. The beat with tlast starts the operation picked by its
// tuser: 0 sum, 1 absolute difference, anything else compare only. The
// block then takes no input until its last result beat is issued: a scan
// pass over the n stored digits finds the compare flags and the final
// carry, and an emit pass produces one result beat per digit, both paced
// by the single read port of the digit store feeding the shared digit
// unit; a sum ends with one carry beat and a compare gives a single beat
// after the scan. Output stalls hold back the emit pass and the last beat.
module decimal_add_sub_compare #(
  parameter int DIGITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] a_digit, [7:4] b_digit
  input  logic [1:0] s_axis_tuser,   // [1:0] req_type
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] result_digit, [7:4] zero
  output logic [2:0] m_axis_tuser,   // [0] a_less_than_b, [1] operands_equal, [2] overflow
  output logic       m_axis_tlast
);
  import dasc_pkg::*;

  localparam int CW = $clog2(DIGITS + 1);
  localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int MW = 2 * DIGIT_W;

  seq_state_t state, state_next;

  logic [CW-1:0]      cnt, cnt_next;
  logic [CW-1:0]      n_dig, n_dig_next;
  logic [AW-1:0]      idx, idx_next;
  logic [OP_W-1:0]    op, op_next;
  logic               ovf_seen, ovf_seen_next;
  logic               lt, lt_next;
  logic               eq, eq_next;
  logic               final_carry, final_carry_next;
  logic               chain, chain_next;

  logic               out_valid, out_valid_next;
  logic [DIGIT_W-1:0] out_digit, out_digit_next;
  logic               out_last, out_last_next;
  logic [FLAG_W-1:0]  out_flags, out_flags_next;

  logic               in_beat;
  logic               out_free;
  logic               has_room;
  logic               idx_last;
  logic               is_sum;
  logic               is_diff;
  logic               full;
  logic               carry_drop;
  logic               beat_ovf;
  logic [FLAG_W-1:0]  beat_flags;

  logic               wr_en;
  logic [MW-1:0]      wr_data;
  logic               rd_en;
  logic [MW-1:0]      rd_data;
  logic [DIGIT_W-1:0] a_rd;
  logic [DIGIT_W-1:0] b_rd;

  alu_req_t           alu_req;
  alu_res_t           alu_res;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid || m_axis_tready;
  assign has_room   = cnt < CW'(DIGITS);
  assign idx_last   = (CW'(idx) + CW'(1)) == n_dig;
  assign is_sum     = op == OP_SUM;
  assign is_diff    = op == OP_DIFF;
  assign full       = n_dig == CW'(DIGITS);
  assign carry_drop = full && final_carry;
  assign beat_ovf   = ovf_seen || (is_sum && carry_drop);
  assign beat_flags = {beat_ovf, eq, lt};

  assign a_rd = rd_data[DIGIT_W-1:0];
  assign b_rd = rd_data[MW-1:DIGIT_W];

  assign wr_en   = in_beat && has_room;
  assign wr_data = {clamp_digit(s_axis_tdata[7:4]), clamp_digit(s_axis_tdata[3:0])};
  assign rd_en   = (state == ST_SCAN_RD) || (state == ST_EMIT_RD);

  dasc_digit_mem #(
    .DEPTH (DIGITS),
    .AW    (AW),
    .WIDTH (MW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // scan adds a+b; emit subtracts smaller from larger for a difference
  always_comb begin
    alu_req.x   = a_rd;
    alu_req.y   = b_rd;
    alu_req.cin = final_carry;
    alu_req.sub = 1'b0;
    if (state == ST_EMIT_OP) begin
      alu_req.cin = chain;
      alu_req.sub = is_diff;
      if (is_diff && lt) begin
        alu_req.x = b_rd;
        alu_req.y = a_rd;
      end
    end
  end

  dasc_digit_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    n_dig_next       = n_dig;
    idx_next         = idx;
    op_next          = op;
    ovf_seen_next    = ovf_seen;
    lt_next          = lt;
    eq_next          = eq;
    final_carry_next = final_carry;
    chain_next       = chain;
    out_valid_next   = out_valid && !m_axis_tready;
    out_digit_next   = out_digit;
    out_last_next    = out_last;
    out_flags_next   = out_flags;
    s_axis_tready    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_beat) begin
          if (has_room) begin
            cnt_next = cnt + CW'(1);
          end else begin
            ovf_seen_next = 1'b1;
          end
          if (s_axis_tlast) begin
            n_dig_next       = has_room ? cnt + CW'(1) : cnt;
            op_next          = s_axis_tuser;
            idx_next         = '0;
            lt_next          = 1'b0;
            eq_next          = 1'b1;
            final_carry_next = 1'b0;
            state_next       = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_OP;
      end
      ST_SCAN_OP: begin
        // higher digits override the flags from lower ones
        if (!alu_res.x_eq_y) begin
          lt_next = alu_res.x_lt_y;
          eq_next = 1'b0;
        end
        final_carry_next = alu_res.cout;
        if (idx_last) begin
          idx_next   = '0;
          chain_next = 1'b0;
          state_next = (is_sum || is_diff) ? ST_EMIT_RD : ST_FINAL;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_OP;
      end
      ST_EMIT_OP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_digit_next = alu_res.digit;
          out_last_next  = is_diff && idx_last;
          out_flags_next = beat_flags;
          chain_next     = alu_res.cout;
          if (idx_last) begin
            if (is_diff) begin
              cnt_next      = '0;
              ovf_seen_next = 1'b0;
              state_next    = ST_IDLE;
            end else begin
              state_next = ST_FINAL;
            end
          end else begin
            idx_next   = idx + AW'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_FINAL: begin
        // carry beat of a sum, or the single beat of a compare
        if (out_free) begin
          out_valid_next = 1'b1;
          out_digit_next = (is_sum && !carry_drop) ? {{(DIGIT_W-1){1'b0}}, final_carry}
                                                   : '0;
          out_last_next  = 1'b1;
          out_flags_next = beat_flags;
          cnt_next       = '0;
          ovf_seen_next  = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ovf_seen  <= ovf_seen_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n_dig       <= n_dig_next;
    idx         <= idx_next;
    op          <= op_next;
    lt          <= lt_next;
    eq          <= eq_next;
    final_carry <= final_carry_next;
    chain       <= chain_next;
    out_digit   <= out_digit_next;
    out_last    <= out_last_next;
    out_flags   <= out_flags_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(8-DIGIT_W){1'b0}}, out_digit};
  assign m_axis_tuser  = out_flags;
  assign m_axis_tlast  = out_last;

endmodule

FILE: hdl/dasc_digit_mem.sv
// ----------------------------------------------------------------------------
// dasc_digit_mem: operand digit store
// One write port and one read port; read data is registered and holds
// between reads. Each word packs the right digit above the left digit.
// ----------------------------------------------------------------------------
module dasc_digit_mem #(
  parameter int DEPTH  = 32,
  parameter int AW     = 5,
  parameter int WIDTH  = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/dasc_digit_alu.sv
// ----------------------------------------------------------------------------
// dasc_digit_alu: one-digit decimal adder / subtractor / comparator
// Adds with decimal carry or subtracts with borrow, and compares the digits.
// ----------------------------------------------------------------------------
module dasc_digit_alu (
  input  dasc_pkg::alu_req_t req,
  output dasc_pkg::alu_res_t res
);
  import dasc_pkg::*;

  logic [DIGIT_W:0] xw;
  logic [DIGIT_W:0] sum_w;
  logic [DIGIT_W:0] sub_t;
  logic [DIGIT_W:0] d_w;
  logic             c_out;

  assign xw    = {1'b0, req.x};
  assign sum_w = xw + {1'b0, req.y} + {{DIGIT_W{1'b0}}, req.cin};
  assign sub_t = {1'b0, req.y} + {{DIGIT_W{1'b0}}, req.cin};

  always_comb begin
    if (req.sub) begin
      if (xw < sub_t) begin
        d_w   = xw + DIGIT_BASE - sub_t;
        c_out = 1'b1;
      end else begin
        d_w   = xw - sub_t;
        c_out = 1'b0;
      end
    end else begin
      if (sum_w >= DIGIT_BASE) begin
        d_w   = sum_w - DIGIT_BASE;
        c_out = 1'b1;
      end else begin
        d_w   = sum_w;
        c_out = 1'b0;
      end
    end
  end

  assign res.digit  = d_w[DIGIT_W-1:0];
  assign res.cout   = c_out;
  assign res.x_lt_y = req.x < req.y;
  assign res.x_eq_y = req.x == req.y;

endmodule

FILE: hdl/dasc_checker.sv
// ----------------------------------------------------------------------------
// dasc_checker: port-level checks for decimal_add_sub_compare
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module dasc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // every result digit is decimal and the pad bits stay zero
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9) && (m_axis_tdata[7:4] == 4'd0))
    else $error("result digit out of range");

  // less-than and equal never both set
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("less-than and equal both set");

  // the last digit pair starts an operation, so input stalls next cycle
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after the last digit pair");

endmodule

bind decimal_add_sub_compare dasc_checker u_dasc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/tb_decimal_add_sub_compare.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_add_sub_compare: stream-level test of the BCD add/sub/compare block
// Sends digit pairs as input beats and predicts every result beat: sum digits
// with carry, absolute difference digits, compare flags and overflow. Each
// accepted result beat is checked field by field against the oldest predicted
// beat. Directed cases come first, then random operands under several
// idle/stall mixes, a long output hold-off and pauses that let results drain.
// ----------------------------------------------------------------------------
module tb_decimal_add_sub_compare;
  import dasc_pkg::*;

  localparam int DIGITS        = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 4 * DIGITS + 20;

  // unused operation code, handled as compare only
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               lt;
    logic               eq;
    logic               ovf;
  } digit_beat_t;

  logic       clk;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [3:0] a_digit, [7:4] b_digit
  logic [1:0] s_axis_tuser  = '0;   // [1:0] req_type
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [3:0] result_digit, [7:4] zero
  logic [2:0] m_axis_tuser;         // [0] a_less_than_b, [1] operands_equal, [2] overflow
  logic       m_axis_tlast;

  // predicted copy of the block's digit stores
  logic [DIGIT_W-1:0] lhs_store [DIGITS];
  logic [DIGIT_W-1:0] rhs_store [DIGITS];
  int                 held_count    = 0;
  logic               dropped_digit = 1'b0;
  digit_beat_t        result_beats_due [$];

  int          fail_count = 0;
  int          items_sent = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  logic        recv_hold  = 1'b0;
  int unsigned cycle_count;
  event        recv_hold_go;

  decimal_add_sub_compare #(
    .DIGITS(DIGITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store one digit pair; on the last pair, queue the whole operation's beats.
  task automatic compute_bcd_results(input logic [OP_W-1:0] op,
                                     input logic [DIGIT_W-1:0] a_in,
                                     input logic [DIGIT_W-1:0] b_in,
                                     input logic last);
    logic [DIGIT_W-1:0] sum_dig [DIGITS];
    logic [DIGIT_W-1:0] a_dig, b_dig, carry_dig;
    logic               lt, eq, ovf, carry, borrow;
    int                 n, total, big_d, small_d;
    a_dig = (a_in > DIGIT_MAX) ? DIGIT_MAX : a_in;
    b_dig = (b_in > DIGIT_MAX) ? DIGIT_MAX : b_in;
    if (held_count < DIGITS) begin
      lhs_store[held_count] = a_dig;
      rhs_store[held_count] = b_dig;
      held_count++;
    end else begin
      dropped_digit = 1'b1;
    end
    if (!last) return;

    n   = held_count;
    ovf = dropped_digit;
    lt  = 1'b0;
    eq  = 1'b1;
    for (int i = n - 1; i >= 0; i--) begin
      if (lhs_store[i] != rhs_store[i]) begin
        lt = lhs_store[i] < rhs_store[i];
        eq = 1'b0;
        break;
      end
    end

    case (op)
      OP_SUM: begin
        carry = 1'b0;
        for (int i = 0; i < n; i++) begin
          total = lhs_store[i] + rhs_store[i] + carry;
          carry = (total >= 10);
          sum_dig[i] = carry ? DIGIT_W'(total - 10) : DIGIT_W'(total);
        end
        carry_dig = {3'b000, carry};
        // carry past a full store is lost and flagged on every beat
        if (n >= DIGITS && carry) begin
          ovf       = 1'b1;
          carry_dig = '0;
        end
        for (int i = 0; i < n; i++)
          result_beats_due.push_back('{sum_dig[i], 1'b0, lt, eq, ovf});
        result_beats_due.push_back('{carry_dig, 1'b1, lt, eq, ovf});
      end
      OP_DIFF: begin
        borrow = 1'b0;
        for (int i = 0; i < n; i++) begin
          big_d   = lt ? rhs_store[i] : lhs_store[i];
          small_d = (lt ? lhs_store[i] : rhs_store[i]) + borrow;
          if (big_d < small_d) begin
            total  = big_d + 10 - small_d;
            borrow = 1'b1;
          end else begin
            total  = big_d - small_d;
            borrow = 1'b0;
          end
          result_beats_due.push_back('{DIGIT_W'(total), i == n - 1, lt, eq, ovf});
        end
      end
      default: begin
        result_beats_due.push_back('{'0, 1'b1, lt, eq, ovf});
      end
    endcase

    held_count    = 0;
    dropped_digit = 1'b0;
  endtask

  task automatic send_digit_pair(input logic [OP_W-1:0] op, input logic [DIGIT_W-1:0] a,
                                 input logic [DIGIT_W-1:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    compute_bcd_results(op, a, b, last);
    items_sent++;
  endtask

  // Drop valid and hold the sender until every predicted beat has come out.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (result_beats_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_operands(input int width);
    logic [DIGIT_W-1:0] a_d, b_d;
    logic               mirror;
    mirror = ($urandom_range(4) == 0);
    for (int i = 0; i < width; i++) begin
      a_d = ($urandom_range(9) == 0) ? DIGIT_W'($urandom_range(15, 10))
                                     : DIGIT_W'($urandom_range(9));
      b_d = mirror ? a_d
                   : (($urandom_range(9) == 0) ? DIGIT_W'($urandom_range(15, 10))
                                               : DIGIT_W'($urandom_range(9)));
      send_digit_pair(OP_W'($urandom_range(3)), a_d, b_d, i == width - 1);
    end
  endtask

  task automatic run_random_phase(input int quota, input int idle, input int stall);
    int start, r, width;
    idle_pct  = idle;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(99);
      if (r < 80)      width = $urandom_range(6, 1);
      else if (r < 94) width = $urandom_range(31, 7);
      else             width = $urandom_range(DIGITS + 8, DIGITS);
      send_random_operands(width);
      if ($urandom_range(9) == 0) wait_results_drained();
    end
  endtask

  task automatic test_single_digit_ops();
    idle_pct  = 0;
    stall_pct = 0;
    send_digit_pair(OP_SUM, 4'd9, 4'd9, 1'b1);
    send_digit_pair(OP_DIFF, 4'd3, 4'd7, 1'b1);
    send_digit_pair(OP_DIFF, 4'd8, 4'd2, 1'b1);
    send_digit_pair(OP_CMP, 4'd5, 4'd5, 1'b1);
    send_digit_pair(OP_UNUSED, 4'd0, 4'd0, 1'b1);
  endtask

  task automatic test_clamped_digits();
    send_digit_pair(OP_DIFF, 4'd15, 4'd10, 1'b0);
    send_digit_pair(OP_SUM, 4'd12, 4'd3, 1'b1);
    // both load as nine, so the compare reports equal
    send_digit_pair(OP_CMP, 4'd15, 4'd9, 1'b1);
  endtask

  task automatic test_borrow_chain();
    // 100 - 1, then 1 - 100, then equal operands
    send_digit_pair(OP_UNUSED, 4'd0, 4'd1, 1'b0);
    send_digit_pair(OP_CMP, 4'd0, 4'd0, 1'b0);
    send_digit_pair(OP_DIFF, 4'd1, 4'd0, 1'b1);
    send_digit_pair(OP_SUM, 4'd1, 4'd0, 1'b0);
    send_digit_pair(OP_UNUSED, 4'd0, 4'd0, 1'b0);
    send_digit_pair(OP_DIFF, 4'd0, 4'd1, 1'b1);
    send_digit_pair(OP_SUM, 4'd4, 4'd4, 1'b0);
    send_digit_pair(OP_DIFF, 4'd7, 4'd7, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_store_full();
    // all nines past the store: carry out of the top digit is lost
    for (int i = 0; i < DIGITS + 2; i++)
      send_digit_pair(OP_SUM, 4'd9, 4'd9, i == DIGITS + 1);
    // dropped pairs flag overflow on a compare too
    for (int i = 0; i <= DIGITS; i++)
      send_digit_pair(OP_CMP, DIGIT_W'($urandom_range(9)), DIGIT_W'($urandom_range(9)),
                      i == DIGITS);
    wait_results_drained();
  endtask

  task automatic test_output_hold_off();
    idle_pct  = 0;
    stall_pct = 0;
    -> recv_hold_go;
    for (int i = 0; i < 12; i++) send_random_operands($urandom_range(2, 1));
    wait_results_drained();
  endtask

  // Long receiver hold-off, counted here so the sender keeps offering beats.
  initial begin
    forever begin
      @(recv_hold_go);
      recv_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      recv_hold <= 1'b0;
    end
  end

  task automatic check_field(input string field, input logic [DIGIT_W-1:0] want,
                             input logic [DIGIT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    digit_beat_t due_beat;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (result_beats_due.size() == 0) begin
        $error("result beat with nothing predicted: digit %0d", m_axis_tdata[3:0]);
        fail_count++;
      end else begin
        due_beat = result_beats_due.pop_front();
        check_field("result_digit", due_beat.digit, m_axis_tdata[3:0]);
        check_field("tdata_pad", '0, m_axis_tdata[7:4]);
        check_field("last_result", due_beat.last, m_axis_tlast);
        check_field("a_less_than_b", due_beat.lt, m_axis_tuser[0]);
        check_field("operands_equal", due_beat.eq, m_axis_tuser[1]);
        check_field("overflow", due_beat.ovf, m_axis_tuser[2]);
      end
    end
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d beats still due", cycle_count,
           result_beats_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_digit_ops();
    test_clamped_digits();
    test_borrow_chain();
    test_store_full();
    run_random_phase(90, 0, 0);
    run_random_phase(100, 71, 0);
    test_output_hold_off();
    run_random_phase(100, 0, 71);
    run_random_phase(60, 6, 6);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (result_beats_due.size() != 0) begin
      $error("%0d predicted beats never arrived", result_beats_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
